@@ src/lir_pkg.sv @@
// Shared types and constants for the linear-interpolation resampler.
// No dependencies; imported by every module of the block.
`default_nettype none

package lir_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int STEP_W    = 19;
  localparam int MAX_OUT   = 8;
  localparam int CNT_W     = $clog2(MAX_OUT);
  localparam logic [14:0] CLAMP_MAG = 15'h7fff;

  typedef enum logic [1:0] {
    KIND_PASS   = 2'd0,
    KIND_PRIME  = 2'd1,
    KIND_INTERP = 2'd2
  } item_kind_t;

  typedef struct packed {
    item_kind_t          kind;
    logic [SAMPLE_W-1:0] sample;
  } lir_entry_t;

  typedef struct packed {
    logic       push;
    lir_entry_t entry;
  } lir_push_t;

endpackage

`default_nettype wire

@@ src/lir_front.sv @@
// Front end: input handshake, phase_step register and item classification.
// Depends on lir_pkg; feeds lir_queue.
`default_nettype none

module lir_front
  import lir_pkg::*;
#(
  parameter int  FRAC_BITS = 16,
  localparam int PW        = (FRAC_BITS > STEP_W ? FRAC_BITS : STEP_W) + 1
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [STEP_W-1:0]   cfg_wdata,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [SAMPLE_W-1:0] s_axis_tdata,
  input  wire logic                q_full,
  output lir_push_t                q_wr,
  output logic [PW-1:0]            step
);

  localparam logic [PW-1:0] ONE = PW'(1) << FRAC_BITS;

  logic have_prev;
  logic xfer;

  assign s_axis_tready = !q_full;
  assign xfer          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    q_wr.push         = 1'b0;
    q_wr.entry.sample = s_axis_tdata;
    q_wr.entry.kind   = KIND_INTERP;
    if (step == ONE) begin
      q_wr.push       = xfer;
      q_wr.entry.kind = KIND_PASS;
    end else if (step == '0) begin
      q_wr.push       = 1'b0;
    end else if (!have_prev) begin
      q_wr.push       = xfer;
      q_wr.entry.kind = KIND_PRIME;
    end else begin
      q_wr.push       = xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= ONE;
      have_prev <= 1'b0;
    end else begin
      if (cfg_we) begin
        step <= PW'(cfg_wdata);
      end
      if (q_wr.push && q_wr.entry.kind == KIND_PRIME) begin
        have_prev <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/lir_queue.sv @@
// Two-entry queue between front end and back end.
// Depends on lir_pkg.
`default_nettype none

module lir_queue
  import lir_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  lir_push_t wr,
  output logic      full,
  output logic      not_empty,
  input  wire logic pop,
  output lir_entry_t rd_entry
);

  lir_entry_t  mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign rd_entry  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr.push) begin
      mem[wr_ptr] <= wr.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr.push) wr_ptr <= !wr_ptr;
      if (pop)     rd_ptr <= !rd_ptr;
      count <= count + 2'(wr.push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(wr.push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !not_empty))
    else $error("queue pop while empty");

endmodule

`default_nettype wire

@@ src/lir_back.sv @@
// Back end: phase accumulator, multi-cycle interpolation datapath, output register.
// Depends on lir_pkg; reads entries from lir_queue.
`default_nettype none

module lir_back
  import lir_pkg::*;
#(
  parameter int  FRAC_BITS = 16,
  localparam int PW        = (FRAC_BITS > STEP_W ? FRAC_BITS : STEP_W) + 1
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [PW-1:0]       step,
  input  wire logic                q_valid,
  input  lir_entry_t               q_entry,
  output logic                     q_pop,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [SAMPLE_W-1:0]      m_axis_tdata,
  output logic                     m_axis_tlast
);

  localparam int PRW = FRAC_BITS + 18;
  localparam int NW  = PRW + 15;
  localparam logic [PW-1:0] ONE  = PW'(1) << FRAC_BITS;
  localparam logic [NW:0]   HALF = (NW+1)'(1) << (FRAC_BITS + 14);
  localparam int RQW = NW + 1 - (FRAC_BITS + 15);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_SUM   = 6'b000100,
    ST_SCALE = 6'b001000,
    ST_ABS   = 6'b010000,
    ST_RND   = 6'b100000
  } back_state_t;

  back_state_t          state;
  logic [PW-1:0]        phase;
  logic [PW-1:0]        phase_add;
  logic [CNT_W-1:0]     cnt;
  logic [SAMPLE_W-1:0]  prev;
  logic [SAMPLE_W-1:0]  cur;
  logic signed [PRW-1:0] prod;
  logic signed [PRW-1:0] v;
  logic signed [NW-1:0]  num;
  logic [NW-1:0]        mag;
  logic                 neg;

  logic                 out_free;
  logic                 load_out;
  logic signed [16:0]   diff;
  logic signed [FRAC_BITS:0] frac_s;
  logic [NW:0]          rsum;
  logic [RQW-1:0]       rq;
  logic [14:0]          rc;
  logic [SAMPLE_W-1:0]  val;
  logic                 last;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign diff     = $signed({cur[15], cur}) - $signed({prev[15], prev});
  assign frac_s   = $signed({1'b0, phase[FRAC_BITS-1:0]});
  assign rsum     = {1'b0, mag} + HALF;
  assign rq       = rsum[NW:FRAC_BITS+15];
  assign rc       = (rq > RQW'(CLAMP_MAG)) ? CLAMP_MAG : rq[14:0];
  assign val      = neg ? SAMPLE_W'(~{1'b0, rc} + 16'd1) : {1'b0, rc};
  assign last     = (phase_add >= ONE) || (cnt == CNT_W'(MAX_OUT - 1));

  assign q_pop = (state == ST_IDLE) && q_valid &&
                 ((q_entry.kind != KIND_PASS) || out_free);

  assign load_out = (q_pop && (q_entry.kind == KIND_PASS)) ||
                    ((state == ST_RND) && out_free);

  always_ff @(posedge clk) begin
    case (state)
      ST_MUL: begin
        prod      <= PRW'(diff) * PRW'(frac_s);
        phase_add <= phase + step;
      end
      ST_SUM:   v   <= $signed({{2{prev[15]}}, prev, {FRAC_BITS{1'b0}}}) + prod;
      ST_SCALE: num <= $signed({v, 15'b0}) - NW'(v);
      ST_ABS: begin
        neg <= num[NW-1];
        mag <= num[NW-1] ? NW'(~num + NW'(1)) : NW'(num);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      phase         <= '0;
      prev          <= '0;
      cnt           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            case (q_entry.kind)
              KIND_PASS: begin
                m_axis_tdata  <= q_entry.sample;
                m_axis_tlast  <= 1'b1;
              end
              KIND_PRIME: prev <= q_entry.sample;
              default: begin
                cur <= q_entry.sample;
                cnt <= '0;
                if (phase >= ONE) begin
                  phase <= phase - ONE;
                  prev  <= q_entry.sample;
                end else begin
                  state <= ST_MUL;
                end
              end
            endcase
          end
        end
        ST_MUL:   state <= ST_SUM;
        ST_SUM:   state <= ST_SCALE;
        ST_SCALE: state <= ST_ABS;
        ST_ABS:   state <= ST_RND;
        ST_RND: begin
          if (out_free) begin
            m_axis_tdata  <= val;
            m_axis_tlast  <= last;
            if (last) begin
              phase <= (phase_add >= ONE) ? phase_add - ONE : '0;
              prev  <= cur;
              state <= ST_IDLE;
            end else begin
              phase <= phase_add;
              cnt   <= cnt + CNT_W'(1);
              state <= ST_MUL;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_phase_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL |-> phase < ONE)
    else $error("interpolation started with phase at or above one");
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RND && out_free && last) |=> state == ST_IDLE)
    else $error("run did not end after last result");

endmodule

`default_nettype wire

@@ src/linear_interp_resampler.sv @@
// Top level of the linear-interpolation resampler.
// Depends on lir_pkg, lir_front, lir_queue, lir_back.
//
//   channel   dir  signals                          payload
//   s_axis    in   tvalid/tready/tdata[15:0]        sample_in
//   m_axis    out  tvalid/tready/tdata[15:0]/tlast  sample_out, last_of_run
//   cfg       in   cfg_we/cfg_wdata[18:0]           phase_step
//
// Pass-through items go from the queue straight into the output register; the next
// may follow once it is free. An interpolating input yields n results (n up to 8)
// via the five-step multiply/scale/round sequence in the back end, which forms one
// result at a time. A priming or dropped input yields no result. A two-entry queue
// lets the input side keep accepting while the back end works or output is stalled.
// Reset (rst, synchronous) clears phase, previous sample and sets phase_step to 1.0.
`default_nettype none

module linear_interp_resampler
  import lir_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [STEP_W-1:0]    cfg_wdata,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [SAMPLE_W-1:0]  s_axis_tdata,   // [15:0] sample_in
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [SAMPLE_W-1:0]       m_axis_tdata,   // [15:0] sample_out
  output logic                      m_axis_tlast    // last_of_run
);

  localparam int PW = (FRAC_BITS > STEP_W ? FRAC_BITS : STEP_W) + 1;

  lir_push_t     q_wr;
  logic          q_full;
  logic          q_not_empty;
  logic          q_pop;
  lir_entry_t    q_entry;
  logic [PW-1:0] step;

  lir_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full        (q_full),
    .q_wr          (q_wr),
    .step          (step)
  );

  lir_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr        (q_wr),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .rd_entry  (q_entry)
  );

  lir_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .q_valid       (q_not_empty),
    .q_entry       (q_entry),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire
